### rtl/dqsv_pkg.sv
`default_nettype none

package dqsv_pkg;

   // sine table size, entries per electrical turn
   localparam int unsigned SINE_DEPTH = 1024;
   localparam int IDX_W = $clog2(SINE_DEPTH);

   localparam int NUM_STAGES = 11;

   localparam int REQ_W = 48;
   localparam int RSP_W = 56;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // sqrt(3) in Q15
   localparam logic [15:0] SQRT3_Q15 = 16'd56756;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;
   // taylor series denominators, already scaled by 2^30
   localparam logic [63:0] SERIES_DEN [5] = '{
      64'd118111600640, 64'd77309411328, 64'd45097156608,
      64'd21474836480, 64'd6442450944
   };

   // register indexes of the control port
   localparam logic [CSR_IDX_W-1:0] CSR_INV_BUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_TOP = 2'd2;

   // sextant codes {c,b,a} of the six active sectors
   localparam logic [2:0] SEXT_S1 = 3'd3;
   localparam logic [2:0] SEXT_S2 = 3'd1;
   localparam logic [2:0] SEXT_S3 = 3'd5;
   localparam logic [2:0] SEXT_S4 = 3'd4;
   localparam logic [2:0] SEXT_S5 = 3'd6;
   localparam logic [2:0] SEXT_S6 = 3'd2;
   // the two zero vector codes
   localparam logic [2:0] SEXT_ZERO_LO = 3'd0;
   localparam logic [2:0] SEXT_ZERO_HI = 3'd7;

   // one sine table entry in Q1.15, evaluated at elaboration
   function automatic logic signed [16:0] sine_entry(input int unsigned idx);
      int unsigned quad;
      int unsigned frac;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      quad = (4 * idx) / SINE_DEPTH;
      frac = 4 * idx - quad * SINE_DEPTH;
      if (quad[0]) begin
         frac = SINE_DEPTH - frac;
      end
      x = (64'(frac) * HALF_PI_Q30) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      t = ONE_Q30;
      for (int k = 0; k < 5; k++) begin
         t = ONE_Q30 - (x2 * t) / SERIES_DEN[k];
      end
      s = (((x * t) >> 30) + 64'd16384) >> 15;
      if (quad >= 2) begin
         sine_entry = -$signed(17'(s));
      end else begin
         sine_entry = $signed(17'(s));
      end
   endfunction

endpackage

`default_nettype wire

### rtl/dqsv_sine_rom.sv
`default_nettype none

module dqsv_sine_rom (
   input  logic                clock,
   input  logic                en,
   input  logic [15:0]         angle,
   output logic signed [16:0]  sin_val,
   output logic signed [16:0]  cos_val
);

   logic signed [16:0] rom_tbl [dqsv_pkg::SINE_DEPTH];
   logic [31:0] sin_scaled;
   logic [31:0] cos_scaled;
   logic [15:0] cos_angle;
   logic [dqsv_pkg::IDX_W-1:0] sin_idx;
   logic [dqsv_pkg::IDX_W-1:0] cos_idx;

   for (genvar g = 0; g < dqsv_pkg::SINE_DEPTH; g++) begin : g_rom
      assign rom_tbl[g] = dqsv_pkg::sine_entry(g);
   end

   // cosine is the sine a quarter turn ahead
   assign cos_angle = angle + 16'd16384;
   assign sin_scaled = 32'(angle) * 32'(dqsv_pkg::SINE_DEPTH);
   assign cos_scaled = 32'(cos_angle) * 32'(dqsv_pkg::SINE_DEPTH);
   assign sin_idx = sin_scaled[16 +: dqsv_pkg::IDX_W];
   assign cos_idx = cos_scaled[16 +: dqsv_pkg::IDX_W];

   always_ff @(posedge clock) begin
      if (en) begin
         sin_val <= rom_tbl[sin_idx];
         cos_val <= rom_tbl[cos_idx];
      end
   end

endmodule

`default_nettype wire

### rtl/dq_to_svpwm_duty_unit.sv
`default_nettype none

// channel   dir  handshake                 payload
// req_      in   req_tvalid / req_tready    tdata: volt_d, volt_q, angle
// rsp_      out  rsp_tvalid / rsp_tready    tdata: compare_a/b/c, sextant_code
// csr_      in   csr_valid / csr_ready      csr_index, csr_data
//
// eleven register stages; one transaction in and one out per cycle when not stalled
// the multipliers are rotation, sqrt3, vector time and top, in that order
// reset (synchronous) empties the pipeline and loads the register defaults
// each stage holds its item while the one after it is full and stalled, so
// bubbles close up and a stall on rsp_ drops and repeats nothing
// a write reaches the time scaling via k_part_ff (period), then k_prod_ff and kq_ff

module dq_to_svpwm_duty_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] volt_d, [31:16] volt_q, [47:32] angle
   input  logic [dqsv_pkg::REQ_W-1:0]         req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] compare_a, [31:16] compare_b, [47:32] compare_c,
   // [50:48] sextant_code, [55:51] zero
   output logic [dqsv_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dqsv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dqsv_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int N = dqsv_pkg::NUM_STAGES;

   // clamp doubled time into a doubled duty of 0..65536
   function automatic logic [16:0] duty_of(input logic signed [31:0] t2);
      logic signed [31:0] diff;
      diff = 32'sd65536 - t2;
      if (t2 <= 32'sd0) begin
         duty_of = 17'h10000;
      end else if (t2 >= 32'sd65536) begin
         duty_of = 17'd0;
      end else begin
         duty_of = diff[16:0];
      end
   endfunction

   // ---------------- configuration
   logic [15:0] inv_bus_ff;
   logic [15:0] period_ff;
   logic [15:0] pwm_top_ff;
   logic [31:0] k_part_ff;
   logic [47:0] k_prod_ff;
   logic [33:0] kq_ff;
   logic [48:0] kq_sum;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_bus_ff <= 16'd2731;
         period_ff <= 16'd16384;
         pwm_top_ff <= 16'd4096;
      end else if (csr_valid) begin
         case (csr_index)
            dqsv_pkg::CSR_INV_BUS: inv_bus_ff <= csr_data;
            dqsv_pkg::CSR_PERIOD: period_ff <= csr_data;
            dqsv_pkg::CSR_PWM_TOP: pwm_top_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // period * sqrt3 * inverse bus voltage, Q30
   assign kq_sum = 49'(k_prod_ff) + 49'd16384;

   always_ff @(posedge clock) begin
      k_part_ff <= 32'(period_ff) * 32'(dqsv_pkg::SQRT3_Q15);
      k_prod_ff <= 48'(k_part_ff) * 48'(inv_bus_ff);
      kq_ff <= kq_sum[48:15];
   end

   // ---------------- pipeline control
   logic [N-1:0] vld_ff;
   logic [N-1:0] vld_in;
   logic [N-1:0] en;

   always_comb begin
      en[N-1] = !vld_ff[N-1] || rsp_tready;
      for (int k = N - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[0] = en[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < N; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[N-1];

   // ---------------- stage 1: table lookup
   logic signed [15:0] s1_vd_ff;
   logic signed [15:0] s1_vq_ff;
   logic signed [16:0] s1_sin;
   logic signed [16:0] s1_cos;

   dqsv_sine_rom u_sine_rom (
      .clock   (clock),
      .en      (en[0]),
      .angle   (req_tdata[47:32]),
      .sin_val (s1_sin),
      .cos_val (s1_cos)
   );

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_vd_ff <= req_tdata[15:0];
         s1_vq_ff <= req_tdata[31:16];
      end
   end

   // ---------------- stage 2: rotation products
   logic signed [32:0] s2_dc_ff;
   logic signed [32:0] s2_qs_ff;
   logic signed [32:0] s2_ds_ff;
   logic signed [32:0] s2_qc_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_dc_ff <= s1_vd_ff * s1_cos;
         s2_qs_ff <= s1_vq_ff * s1_sin;
         s2_ds_ff <= s1_vd_ff * s1_sin;
         s2_qc_ff <= s1_vq_ff * s1_cos;
      end
   end

   // ---------------- stage 3: alpha, beta
   logic signed [33:0] alpha_sum;
   logic signed [33:0] beta_sum;
   logic signed [17:0] s3_alpha_ff;
   logic signed [17:0] s3_beta_ff;

   assign alpha_sum = 34'(s2_dc_ff) - 34'(s2_qs_ff) + 34'sd16384;
   assign beta_sum = 34'(s2_ds_ff) + 34'(s2_qc_ff) + 34'sd16384;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_alpha_ff <= alpha_sum[32:15];
         s3_beta_ff <= beta_sum[32:15];
      end
   end

   // ---------------- stage 4: sqrt3 * alpha
   logic signed [35:0] s4_m_ff;
   logic signed [17:0] s4_beta_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_m_ff <= s3_alpha_ff * $signed({1'b0, dqsv_pkg::SQRT3_Q15});
         s4_beta_ff <= s3_beta_ff;
      end
   end

   // ---------------- stage 5: sector projections
   logic signed [35:0] beta_sh;
   logic signed [35:0] vb_sum;
   logic signed [35:0] vc_sum;
   logic signed [18:0] s5_va_ff;
   logic signed [18:0] s5_vb_ff;
   logic signed [18:0] s5_vc_ff;

   assign beta_sh = 36'(s4_beta_ff) <<< 15;
   assign vb_sum = s4_m_ff - beta_sh + 36'sd32768;
   assign vc_sum = -s4_m_ff - beta_sh + 36'sd32768;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_va_ff <= 19'(s4_beta_ff);
         s5_vb_ff <= vb_sum[34:16];
         s5_vc_ff <= vc_sum[34:16];
      end
   end

   // ---------------- stage 6: sextant and operand select
   logic [2:0] code_in;
   logic signed [18:0] p_op_in;
   logic signed [18:0] r_op_in;
   logic [2:0] s6_code_ff;
   logic signed [18:0] s6_p_ff;
   logic signed [18:0] s6_r_ff;

   always_comb begin
      code_in = {s5_vc_ff > 19'sd0, s5_vb_ff > 19'sd0, s5_va_ff > 19'sd0};
      case (code_in)
         dqsv_pkg::SEXT_S1: begin
            p_op_in = s5_vb_ff;
            r_op_in = s5_va_ff;
         end
         dqsv_pkg::SEXT_S2: begin
            p_op_in = -s5_vc_ff;
            r_op_in = -s5_vb_ff;
         end
         dqsv_pkg::SEXT_S3: begin
            p_op_in = s5_va_ff;
            r_op_in = s5_vc_ff;
         end
         dqsv_pkg::SEXT_S4: begin
            p_op_in = -s5_va_ff;
            r_op_in = -s5_vb_ff;
         end
         dqsv_pkg::SEXT_S5: begin
            p_op_in = s5_vc_ff;
            r_op_in = s5_vb_ff;
         end
         dqsv_pkg::SEXT_S6: begin
            p_op_in = -s5_vc_ff;
            r_op_in = -s5_va_ff;
         end
         default: begin
            // zero vector
            p_op_in = '0;
            r_op_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_code_ff <= code_in;
         s6_p_ff <= p_op_in;
         s6_r_ff <= r_op_in;
      end
   end

   // ---------------- stage 7: scale by k
   logic signed [53:0] s7_pp_ff;
   logic signed [53:0] s7_rp_ff;
   logic [2:0] s7_code_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s7_pp_ff <= s6_p_ff * $signed({1'b0, kq_ff});
         s7_rp_ff <= s6_r_ff * $signed({1'b0, kq_ff});
         s7_code_ff <= s6_code_ff;
      end
   end

   // ---------------- stage 8: round active times to Q15
   logic signed [53:0] p_sum;
   logic signed [53:0] r_sum;
   logic signed [28:0] s8_p_ff;
   logic signed [28:0] s8_r_ff;
   logic [2:0] s8_code_ff;

   assign p_sum = s7_pp_ff + 54'sd16777216;
   assign r_sum = s7_rp_ff + 54'sd16777216;

   always_ff @(posedge clock) begin
      if (en[7]) begin
         s8_p_ff <= p_sum[53:25];
         s8_r_ff <= r_sum[53:25];
         s8_code_ff <= s7_code_ff;
      end
   end

   // ---------------- stage 9: doubled phase times
   logic signed [31:0] ts_ext;
   logic signed [31:0] p_ext;
   logic signed [31:0] r_ext;
   logic signed [31:0] t_pr;
   logic signed [31:0] t_p;
   logic signed [31:0] t_r;
   logic signed [31:0] t_z;
   logic signed [31:0] ta_in;
   logic signed [31:0] tb_in;
   logic signed [31:0] tc_in;
   logic signed [31:0] s9_ta_ff;
   logic signed [31:0] s9_tb_ff;
   logic signed [31:0] s9_tc_ff;
   logic [2:0] s9_code_ff;

   assign ts_ext = {15'd0, period_ff, 1'b0};
   assign p_ext = 32'(s8_p_ff);
   assign r_ext = 32'(s8_r_ff);
   // z = ts - p - r, so 2p+2r+z = ts+p+r and so on
   assign t_pr = ts_ext + p_ext + r_ext;
   assign t_p = ts_ext + p_ext - r_ext;
   assign t_r = ts_ext - p_ext + r_ext;
   assign t_z = ts_ext - p_ext - r_ext;

   always_comb begin
      case (s8_code_ff)
         dqsv_pkg::SEXT_S1: begin
            ta_in = t_pr;
            tb_in = t_r;
            tc_in = t_z;
         end
         dqsv_pkg::SEXT_S2: begin
            ta_in = t_p;
            tb_in = t_pr;
            tc_in = t_z;
         end
         dqsv_pkg::SEXT_S3: begin
            ta_in = t_z;
            tb_in = t_pr;
            tc_in = t_r;
         end
         dqsv_pkg::SEXT_S4: begin
            ta_in = t_z;
            tb_in = t_r;
            tc_in = t_pr;
         end
         dqsv_pkg::SEXT_S5: begin
            ta_in = t_r;
            tb_in = t_z;
            tc_in = t_pr;
         end
         dqsv_pkg::SEXT_S6: begin
            ta_in = t_pr;
            tb_in = t_z;
            tc_in = t_r;
         end
         default: begin
            // zero vector: full duty on all phases
            ta_in = '0;
            tb_in = '0;
            tc_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         s9_ta_ff <= ta_in;
         s9_tb_ff <= tb_in;
         s9_tc_ff <= tc_in;
         s9_code_ff <= s8_code_ff;
      end
   end

   // ---------------- stage 10: duty clamp
   logic [16:0] s10_da_ff;
   logic [16:0] s10_db_ff;
   logic [16:0] s10_dc_ff;
   logic [2:0] s10_code_ff;

   always_ff @(posedge clock) begin
      if (en[9]) begin
         s10_da_ff <= duty_of(s9_ta_ff);
         s10_db_ff <= duty_of(s9_tb_ff);
         s10_dc_ff <= duty_of(s9_tc_ff);
         s10_code_ff <= s9_code_ff;
      end
   end

   // ---------------- stage 11: compare values, output register
   logic [32:0] cmp_a_prod;
   logic [32:0] cmp_b_prod;
   logic [32:0] cmp_c_prod;
   logic [15:0] s11_cmp_a_ff;
   logic [15:0] s11_cmp_b_ff;
   logic [15:0] s11_cmp_c_ff;
   logic [2:0] s11_code_ff;

   assign cmp_a_prod = 33'(s10_da_ff) * 33'(pwm_top_ff);
   assign cmp_b_prod = 33'(s10_db_ff) * 33'(pwm_top_ff);
   assign cmp_c_prod = 33'(s10_dc_ff) * 33'(pwm_top_ff);

   always_ff @(posedge clock) begin
      if (en[10]) begin
         s11_cmp_a_ff <= cmp_a_prod[31:16];
         s11_cmp_b_ff <= cmp_b_prod[31:16];
         s11_cmp_c_ff <= cmp_c_prod[31:16];
         s11_code_ff <= s10_code_ff;
      end
   end

   assign rsp_tdata = {5'd0, s11_code_ff, s11_cmp_c_ff, s11_cmp_b_ff, s11_cmp_a_ff};

endmodule

`default_nettype wire

### rtl/dqsv_checker.sv
`default_nettype none

module dqsv_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [dqsv_pkg::RSP_W-1:0]   rsp_tdata
);

   logic [15:0] cmp_a;
   logic [15:0] cmp_b;
   logic [15:0] cmp_c;
   logic [2:0] code;

   assign cmp_a = rsp_tdata[15:0];
   assign cmp_b = rsp_tdata[31:16];
   assign cmp_c = rsp_tdata[47:32];
   assign code = rsp_tdata[50:48];

   // pipeline is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result presented right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // zero vector drives all three phases alike
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (code == dqsv_pkg::SEXT_ZERO_LO || code == dqsv_pkg::SEXT_ZERO_HI) |->
         cmp_a == cmp_b && cmp_b == cmp_c)
      else $error("zero vector with unequal compares");

   // in the first sector phase a carries the longest time, c the shortest
   a_sector_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && code == dqsv_pkg::SEXT_S1 |-> cmp_a <= cmp_b && cmp_b <= cmp_c)
      else $error("first sector compares out of order");

endmodule

bind dq_to_svpwm_duty_unit dqsv_checker u_dqsv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### bench/tb.sv
`default_nettype none

module tb;

   typedef longint unsigned u64_type;

   localparam longint ROOT3_Q15 = 56756;
   localparam u64_type QUARTER_TURN_Q30 = 64'd1686629713;
   localparam u64_type UNIT_Q30 = 64'd1073741824;
   localparam logic [dqsv_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 300000;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      logic [15:0] compare_a;
      logic [15:0] compare_b;
      logic [15:0] compare_c;
      logic [2:0]  sextant_code;
   } duty_type;

   typedef enum {RX_FREE, RX_COIN, RX_RHYTHM, RX_SPARSE} rx_mode_type;

   class duty_predictor_type;
      duty_type pending_duties[$];
      longint sine_table[dqsv_pkg::SINE_DEPTH];
      u64_type inv_bus;
      u64_type period;
      u64_type top;
      int fails;
      int results_seen;

      function new();
         u64_type series_div[5] = '{110, 72, 42, 20, 6};
         u64_type x, x2, t, s;
         int unsigned quad, frac;
         for (int i = 0; i < dqsv_pkg::SINE_DEPTH; i++) begin
            quad = (4 * i) / dqsv_pkg::SINE_DEPTH;
            frac = 4 * i - quad * dqsv_pkg::SINE_DEPTH;
            if (quad[0]) begin
               frac = dqsv_pkg::SINE_DEPTH - frac;
            end
            x = (u64_type'(frac) * QUARTER_TURN_Q30) / dqsv_pkg::SINE_DEPTH;
            x2 = (x * x) >> 30;
            t = UNIT_Q30;
            for (int k = 0; k < 5; k++) begin
               t = UNIT_Q30 - (x2 * t) / (series_div[k] << 30);
            end
            s = (((x * t) >> 30) + 64'd16384) >> 15;
            sine_table[i] = (quad >= 2) ? -longint'(s) : longint'(s);
         end
         inv_bus = 2731;
         period = 16384;
         top = 4096;
         fails = 0;
         results_seen = 0;
      endfunction

      function longint sine_at(logic [15:0] a);
         u64_type idx;
         idx = (u64_type'(a) * dqsv_pkg::SINE_DEPTH) >> 16;
         if (idx >= dqsv_pkg::SINE_DEPTH) begin
            idx = dqsv_pkg::SINE_DEPTH - 1;
         end
         return sine_table[idx];
      endfunction

      // add half an lsb, then floor
      function longint round_shift(longint v, int n);
         return (v + (longint'(1) <<< (n - 1))) >>> n;
      endfunction

      function logic [15:0] phase_compare(longint twice_time);
         longint duty;
         duty = 65536 - twice_time;
         if (duty < 0) begin
            duty = 0;
         end
         if (duty > 65536) begin
            duty = 65536;
         end
         return 16'((u64_type'(duty) * top) >> 16);
      endfunction

      function duty_type inverse_park_svpwm(logic signed [15:0] vd, logic signed [15:0] vq,
                                            logic [15:0] ang);
         longint d, q, sn, cs, alpha, beta, va, vb, vc, gain, span, p, r, z;
         longint a2, b2, c2;
         logic [15:0] cos_ang;
         logic [2:0] code;
         duty_type res;
         d = longint'(vd);
         q = longint'(vq);
         cos_ang = ang + 16'd16384;
         sn = sine_at(ang);
         cs = sine_at(cos_ang);
         alpha = round_shift(d * cs - q * sn, 15);
         beta = round_shift(d * sn + q * cs, 15);
         va = beta;
         vb = round_shift(ROOT3_Q15 * alpha - 32768 * beta, 16);
         vc = round_shift(-ROOT3_Q15 * alpha - 32768 * beta, 16);
         code = {vc > 0, vb > 0, va > 0};
         gain = longint'((period * u64_type'(ROOT3_Q15) * inv_bus + 64'd16384) >> 15);
         span = longint'(period) * 2;
         a2 = 0;
         b2 = 0;
         c2 = 0;
         case (code)
            dqsv_pkg::SEXT_S1: begin
               p = round_shift(gain * vb, 25);
               r = round_shift(gain * va, 25);
               z = span - p - r;
               a2 = 2 * p + 2 * r + z;
               b2 = 2 * r + z;
               c2 = z;
            end
            dqsv_pkg::SEXT_S2: begin
               p = round_shift(gain * (-vc), 25);
               r = round_shift(gain * (-vb), 25);
               z = span - p - r;
               a2 = 2 * p + z;
               b2 = 2 * r + 2 * p + z;
               c2 = z;
            end
            dqsv_pkg::SEXT_S3: begin
               p = round_shift(gain * va, 25);
               r = round_shift(gain * vc, 25);
               z = span - p - r;
               a2 = z;
               b2 = 2 * p + 2 * r + z;
               c2 = 2 * r + z;
            end
            dqsv_pkg::SEXT_S4: begin
               p = round_shift(gain * (-va), 25);
               r = round_shift(gain * (-vb), 25);
               z = span - p - r;
               a2 = z;
               b2 = 2 * r + z;
               c2 = 2 * p + 2 * r + z;
            end
            dqsv_pkg::SEXT_S5: begin
               p = round_shift(gain * vc, 25);
               r = round_shift(gain * vb, 25);
               z = span - p - r;
               a2 = 2 * r + z;
               b2 = z;
               c2 = 2 * p + 2 * r + z;
            end
            dqsv_pkg::SEXT_S6: begin
               p = round_shift(gain * (-vc), 25);
               r = round_shift(gain * (-va), 25);
               z = span - p - r;
               a2 = 2 * p + 2 * r + z;
               b2 = z;
               c2 = 2 * r + z;
            end
            default: begin
               // zero vector, all phases at full duty
            end
         endcase
         res.compare_a = phase_compare(a2);
         res.compare_b = phase_compare(b2);
         res.compare_c = phase_compare(c2);
         res.sextant_code = code;
         return res;
      endfunction

      function void write_register(logic [dqsv_pkg::CSR_IDX_W-1:0] idx, logic [15:0] val);
         case (idx)
            dqsv_pkg::CSR_INV_BUS: inv_bus = u64_type'(val);
            dqsv_pkg::CSR_PERIOD:  period = u64_type'(val);
            dqsv_pkg::CSR_PWM_TOP: top = u64_type'(val);
            default: ;
         endcase
      endfunction

      function void note_command(logic [15:0] vd, logic [15:0] vq, logic [15:0] ang);
         pending_duties.push_back(inverse_park_svpwm(vd, vq, ang));
      endfunction

      function int pending();
         return pending_duties.size();
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         fails++;
      endtask

      task check_compare(logic [dqsv_pkg::RSP_W-1:0] data);
         duty_type want;
         results_seen++;
         if (pending_duties.size() == 0) begin
            report($sformatf("result %0d (%h) with no transaction pending", results_seen, data));
         end else begin
            want = pending_duties.pop_front();
            if (data[15:0] !== want.compare_a) begin
               report($sformatf("compare_a of result %0d: got %0d, expected %0d",
                                results_seen, data[15:0], want.compare_a));
            end
            if (data[31:16] !== want.compare_b) begin
               report($sformatf("compare_b of result %0d: got %0d, expected %0d",
                                results_seen, data[31:16], want.compare_b));
            end
            if (data[47:32] !== want.compare_c) begin
               report($sformatf("compare_c of result %0d: got %0d, expected %0d",
                                results_seen, data[47:32], want.compare_c));
            end
            if (data[50:48] !== want.sextant_code) begin
               report($sformatf("sextant_code of result %0d: got %0d, expected %0d",
                                results_seen, data[50:48], want.sextant_code));
            end
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [dqsv_pkg::REQ_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [dqsv_pkg::RSP_W-1:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   logic [dqsv_pkg::CSR_IDX_W-1:0] csr_index;
   logic [dqsv_pkg::CSR_DATA_W-1:0] csr_data;

   duty_predictor_type duties;
   int cycle_count = 0;
   bit long_hold_req = 0;
   int hold_left = 0;
   rx_mode_type rx_mode = RX_FREE;
   int mode_left = 0;
   int rhythm_count = 0;

   dq_to_svpwm_duty_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // result side: check, then choose next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         duties.check_compare(rsp_tdata);
      end
      if (long_hold_req) begin
         long_hold_req = 0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 150);
         end
         mode_left--;
         rhythm_count++;
         case (rx_mode)
            RX_FREE:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_RHYTHM: rsp_tready <= (rhythm_count % 3) != 0;
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= 1'b1;
         endcase
      end
   end

   function automatic logic [15:0] random_volt();
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = 16'($urandom_range(0, 8191) - 4096);
         4, 5, 6:    v = 16'($urandom_range(0, 32767) - 16384);
         7, 8:       v = 16'($urandom_range(0, 65535));
         default: begin
            case ($urandom_range(0, 4))
               0: v = 16'h8000;
               1: v = 16'h7fff;
               2: v = 16'h0000;
               3: v = 16'hffff;
               default: v = 16'h0001;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic logic [15:0] random_angle();
      int unsigned edge_pos;
      if ($urandom_range(0, 4) == 0) begin
         // close to a sector boundary
         edge_pos = ($urandom_range(0, 5) * 65536) / 6;
         return 16'(edge_pos + $urandom_range(0, 64) - 32);
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic offer(logic [15:0] vd, logic [15:0] vq, logic [15:0] ang);
      req_tvalid <= 1'b1;
      req_tdata <= {ang, vq, vd};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      duties.note_command(vd, vq, ang);
   endtask

   task automatic idle_for(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      while (duties.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_one(logic [dqsv_pkg::CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      duties.write_register(idx, val);
   endtask

   task automatic program_regs(logic [15:0] inv, logic [15:0] per, logic [15:0] top,
                               bit stray);
      write_one(dqsv_pkg::CSR_INV_BUS, inv);
      write_one(dqsv_pkg::CSR_PERIOD, per);
      write_one(dqsv_pkg::CSR_PWM_TOP, top);
      if (stray) begin
         write_one(CSR_SPARE, 16'($urandom_range(0, 65535)));
      end
      csr_valid <= 1'b0;
   endtask

   task automatic directed_items();
      offer(16'd0, 16'd0, 16'd0);
      offer(16'd1, 16'd0, 16'd0);
      offer(16'h7fff, 16'd0, 16'd0);
      offer(16'h8000, 16'd0, 16'd0);
      offer(16'd0, 16'h7fff, 16'd16384);
      offer(16'd0, 16'h8000, 16'hffff);
      offer(16'h8000, 16'h8000, 16'd32768);
      offer(16'h7fff, 16'h7fff, 16'd49152);
      offer(16'h7fff, 16'h8000, 16'hffff);
      // one command in the middle of each sector
      for (int k = 0; k < 6; k++) begin
         offer(16'd4096, 16'd0, 16'((k * 65536) / 6 + 5461));
      end
      offer(16'd4096, 16'd2048, 16'd10923);
      offer(16'hfc00, 16'd512, 16'd21845);
      // deep overmodulation, absorbed by the clamp
      offer(16'd20000, 16'd20000, 16'd3000);
   endtask

   task automatic run_items(int count, bit squeeze);
      int burst_left;
      int gap;
      burst_left = 0;
      if (squeeze) begin
         // receiver holds off while the sender keeps offering
         long_hold_req = 1;
         burst_left = 120;
      end
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) begin
            req_tvalid <= 1'b0;
            drain();
            burst_left = 0;
         end
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
               idle_for(gap);
            end
         end
         offer(random_volt(), random_volt(), random_angle());
         burst_left--;
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      logic [15:0] inv_v, per_v, top_v;
      duties = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      directed_items();
      run_items(170, 1'b1);

      drain();
      program_regs(16'd0, 16'd0, 16'hffff, 1'b0);
      run_items(150, 1'b0);

      drain();
      program_regs(16'hffff, 16'd32768, 16'd1, 1'b1);
      run_items(150, 1'b0);

      // zero pwm_top
      drain();
      program_regs(16'd2731, 16'd16384, 16'd0, 1'b1);
      run_items(150, 1'b0);

      for (int ph = 0; ph < 7; ph++) begin
         inv_v = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(500, 6000))
                                             : 16'($urandom_range(0, 65535));
         per_v = ($urandom_range(0, 1) == 0) ? 16'd16384 : 16'($urandom_range(0, 32768));
         top_v = ($urandom_range(0, 4) == 0) ? 16'hffff : 16'($urandom_range(1, 65535));
         drain();
         program_regs(inv_v, per_v, top_v, ph[0]);
         run_items(180, ph == 3);
      end

      drain();
      repeat (2 * dqsv_pkg::NUM_STAGES) @(posedge clock);
      if (duties.fails == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
rtl/dqsv_pkg.sv
rtl/dqsv_sine_rom.sv
rtl/dq_to_svpwm_duty_unit.sv
rtl/dqsv_checker.sv
bench/tb.sv
